@@ rtl/slx_pkg.sv @@
// ----------------------------------------------------------------------------
// slx_pkg: shared types and constants of the source lexer
// Character codes, token kinds, scanner modes, the token word and the
// scanner state carried between the step logic and the top level.
// ----------------------------------------------------------------------------
package slx_pkg;

   // widths of the offset and line counters
   localparam int OFFSET_WIDTH = 32;
   localparam int LINE_WIDTH   = 24;
   localparam int KIND_WIDTH   = 5;
   localparam int STATUS_WIDTH = 2;

   // a character produces at most this many tokens
   localparam int RESULT_MAX       = 3;
   localparam int RESULT_CNT_WIDTH = $clog2(RESULT_MAX + 1);

   // result queue, depth a power of two
   localparam int QUEUE_DEPTH     = 4;
   localparam int QUEUE_IDX_WIDTH = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_WIDTH = QUEUE_IDX_WIDTH + 1;

   // character codes
   localparam logic [7:0] CHAR_TAB     = 8'h09;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_CR      = 8'h0D;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_BANG    = 8'h21;
   localparam logic [7:0] CHAR_QUOTE   = 8'h22;
   localparam logic [7:0] CHAR_LPAREN  = 8'h28;
   localparam logic [7:0] CHAR_RPAREN  = 8'h29;
   localparam logic [7:0] CHAR_STAR    = 8'h2A;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_COMMA   = 8'h2C;
   localparam logic [7:0] CHAR_MINUS   = 8'h2D;
   localparam logic [7:0] CHAR_DOT     = 8'h2E;
   localparam logic [7:0] CHAR_SLASH   = 8'h2F;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_SEMI    = 8'h3B;
   localparam logic [7:0] CHAR_LESS    = 8'h3C;
   localparam logic [7:0] CHAR_EQUAL   = 8'h3D;
   localparam logic [7:0] CHAR_GREATER = 8'h3E;
   localparam logic [7:0] CHAR_LBRACE  = 8'h7B;
   localparam logic [7:0] CHAR_RBRACE  = 8'h7D;

   // token kinds
   localparam logic [KIND_WIDTH-1:0] KIND_LPAREN = 5'd0;
   localparam logic [KIND_WIDTH-1:0] KIND_RPAREN = 5'd1;
   localparam logic [KIND_WIDTH-1:0] KIND_LBRACE = 5'd2;
   localparam logic [KIND_WIDTH-1:0] KIND_RBRACE = 5'd3;
   localparam logic [KIND_WIDTH-1:0] KIND_COMMA  = 5'd4;
   localparam logic [KIND_WIDTH-1:0] KIND_DOT    = 5'd5;
   localparam logic [KIND_WIDTH-1:0] KIND_MINUS  = 5'd6;
   localparam logic [KIND_WIDTH-1:0] KIND_PLUS   = 5'd7;
   localparam logic [KIND_WIDTH-1:0] KIND_SEMI   = 5'd8;
   localparam logic [KIND_WIDTH-1:0] KIND_STAR   = 5'd9;
   localparam logic [KIND_WIDTH-1:0] KIND_BANG   = 5'd10;
   localparam logic [KIND_WIDTH-1:0] KIND_SLASH  = 5'd18;
   localparam logic [KIND_WIDTH-1:0] KIND_STRING = 5'd19;
   localparam logic [KIND_WIDTH-1:0] KIND_NUMBER = 5'd20;
   localparam logic [KIND_WIDTH-1:0] KIND_EOF    = 5'd21;

   // token status
   localparam logic [STATUS_WIDTH-1:0] STATUS_OK           = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_UNEXPECTED   = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_UNTERMINATED = 2'd2;

   // pending operator codes, kind is KIND_BANG + 2 * op (+1 with trailing =)
   localparam logic [1:0] OP_BANG    = 2'd0;
   localparam logic [1:0] OP_EQUAL   = 2'd1;
   localparam logic [1:0] OP_LESS    = 2'd2;
   localparam logic [1:0] OP_GREATER = 2'd3;

   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_OPER,
      MODE_SLASH,
      MODE_COMMENT,
      MODE_STRING,
      MODE_INT,
      MODE_DOT,
      MODE_FRAC
   } mode_type;

   typedef struct packed {
      mode_type                mode;
      logic [1:0]              op;
      logic [OFFSET_WIDTH-1:0] start_off;
      logic [OFFSET_WIDTH-1:0] cur_off;
      logic [LINE_WIDTH-1:0]   line;
   } state_type;

   localparam state_type STATE_RESET = '{
      mode:      MODE_IDLE,
      op:        OP_BANG,
      start_off: '0,
      cur_off:   '0,
      line:      LINE_WIDTH'(1)
   };

   typedef struct packed {
      logic [KIND_WIDTH-1:0]   kind;
      logic [OFFSET_WIDTH-1:0] start;
      logic [OFFSET_WIDTH-1:0] length;
      logic [LINE_WIDTH-1:0]   line;
      logic [STATUS_WIDTH-1:0] status;
      logic                    last;
   } token_type;

   // tokens produced by one character, packed in order from slot 0
   typedef struct packed {
      logic [RESULT_CNT_WIDTH-1:0]   count;
      token_type [RESULT_MAX-1:0]    slot;
   } push_type;

   function automatic token_type make_token(
      input logic [KIND_WIDTH-1:0]   kind,
      input logic [OFFSET_WIDTH-1:0] start,
      input logic [OFFSET_WIDTH-1:0] length,
      input logic [LINE_WIDTH-1:0]   line,
      input logic [STATUS_WIDTH-1:0] status
   );
      token_type tok;
      tok.kind   = kind;
      tok.start  = start;
      tok.length = length;
      tok.line   = line;
      tok.status = status;
      tok.last   = 1'b0;
      return tok;
   endfunction

endpackage

@@ rtl/slx_step.sv @@
// ----------------------------------------------------------------------------
// slx_step: scanner step logic
// From the current scanner state and one character (or the end mark) works
// out the next state and the tokens that the character completes.
// ----------------------------------------------------------------------------
module slx_step
   import slx_pkg::*;
(
   input  state_type  state,
   input  logic [7:0] source_char,
   input  logic       end_of_source,
   output state_type  state_next,
   output push_type   push
);

   logic [OFFSET_WIDTH-1:0] pos;
   logic [OFFSET_WIDTH-1:0] nxt;
   logic [OFFSET_WIDTH-1:0] len_pos;
   logic [OFFSET_WIDTH-1:0] len_nxt;
   logic [OFFSET_WIDTH-1:0] len_dot;
   logic [OFFSET_WIDTH-1:0] dot_pos;
   logic [LINE_WIDTH-1:0]   line_inc;
   logic                    pos_gt;
   logic                    is_digit;

   mode_type              fresh_mode;
   logic [1:0]            fresh_op;
   logic                  fresh_tok_valid;
   logic                  fresh_newline;
   token_type             fresh_tok;

   logic [1:0]            pre_n;
   token_type             pre0;
   token_type             pre1;
   token_type             tail;
   logic                  tail_valid;
   logic                  do_fresh;
   logic                  line_bump;
   logic [2:0]            op_code;

   // offsets, spans and saturating counters
   assign pos      = state.cur_off;
   assign nxt      = (&pos) ? pos : pos + OFFSET_WIDTH'(1);
   assign pos_gt   = pos > state.start_off;
   assign len_pos  = pos_gt ? pos - state.start_off : '0;
   assign len_nxt  = (nxt > state.start_off) ? nxt - state.start_off : '0;
   assign len_dot  = pos_gt ? len_pos - OFFSET_WIDTH'(1) : '0;
   assign dot_pos  = pos_gt ? pos - OFFSET_WIDTH'(1) : pos;
   assign line_inc = (&state.line) ? state.line : state.line + LINE_WIDTH'(1);
   assign is_digit = (source_char >= CHAR_ZERO) && (source_char <= CHAR_NINE);

   // decode of a character seen with the scanner idle
   always_comb begin
      fresh_mode      = MODE_IDLE;
      fresh_op        = state.op;
      fresh_tok_valid = 1'b0;
      fresh_newline   = 1'b0;
      fresh_tok       = make_token(KIND_LPAREN, pos, OFFSET_WIDTH'(1), state.line,
                                   STATUS_OK);
      unique case (source_char)
         CHAR_LPAREN: begin
            fresh_tok_valid = 1'b1;
         end
         CHAR_RPAREN: begin
            fresh_tok_valid = 1'b1;
            fresh_tok.kind  = KIND_RPAREN;
         end
         CHAR_LBRACE: begin
            fresh_tok_valid = 1'b1;
            fresh_tok.kind  = KIND_LBRACE;
         end
         CHAR_RBRACE: begin
            fresh_tok_valid = 1'b1;
            fresh_tok.kind  = KIND_RBRACE;
         end
         CHAR_COMMA: begin
            fresh_tok_valid = 1'b1;
            fresh_tok.kind  = KIND_COMMA;
         end
         CHAR_DOT: begin
            fresh_tok_valid = 1'b1;
            fresh_tok.kind  = KIND_DOT;
         end
         CHAR_MINUS: begin
            fresh_tok_valid = 1'b1;
            fresh_tok.kind  = KIND_MINUS;
         end
         CHAR_PLUS: begin
            fresh_tok_valid = 1'b1;
            fresh_tok.kind  = KIND_PLUS;
         end
         CHAR_SEMI: begin
            fresh_tok_valid = 1'b1;
            fresh_tok.kind  = KIND_SEMI;
         end
         CHAR_STAR: begin
            fresh_tok_valid = 1'b1;
            fresh_tok.kind  = KIND_STAR;
         end
         CHAR_BANG: begin
            fresh_mode = MODE_OPER;
            fresh_op   = OP_BANG;
         end
         CHAR_EQUAL: begin
            fresh_mode = MODE_OPER;
            fresh_op   = OP_EQUAL;
         end
         CHAR_LESS: begin
            fresh_mode = MODE_OPER;
            fresh_op   = OP_LESS;
         end
         CHAR_GREATER: begin
            fresh_mode = MODE_OPER;
            fresh_op   = OP_GREATER;
         end
         CHAR_SLASH: begin
            fresh_mode = MODE_SLASH;
         end
         CHAR_QUOTE: begin
            fresh_mode = MODE_STRING;
         end
         CHAR_SPACE, CHAR_CR, CHAR_TAB: begin
            fresh_mode = MODE_IDLE;
         end
         CHAR_NEWLINE: begin
            fresh_newline = 1'b1;
         end
         default: begin
            if (is_digit) begin
               fresh_mode = MODE_INT;
            end else begin
               fresh_tok_valid  = 1'b1;
               fresh_tok.status = STATUS_UNEXPECTED;
            end
         end
      endcase
   end

   // mode update and the tokens ended by this character
   always_comb begin
      state_next = state;
      state_next.cur_off = nxt;
      pre_n      = 2'd0;
      op_code    = {state.op, 1'b0};
      pre0       = make_token(KIND_BANG + KIND_WIDTH'(op_code), state.start_off, len_pos,
                              state.line, STATUS_OK);
      pre1       = make_token(KIND_DOT, dot_pos, OFFSET_WIDTH'(1), state.line, STATUS_OK);
      tail       = fresh_tok;
      tail_valid = 1'b0;
      do_fresh   = 1'b0;
      line_bump  = 1'b0;

      if (end_of_source) begin
         // flush the pending token or tokens, then eof, then back to reset state
         unique case (state.mode)
            MODE_OPER: begin
               pre_n = 2'd1;
            end
            MODE_SLASH: begin
               pre_n       = 2'd1;
               pre0.kind   = KIND_SLASH;
            end
            MODE_STRING: begin
               pre_n       = 2'd1;
               pre0.kind   = KIND_STRING;
               pre0.status = STATUS_UNTERMINATED;
            end
            MODE_INT, MODE_FRAC: begin
               pre_n     = 2'd1;
               pre0.kind = KIND_NUMBER;
            end
            MODE_DOT: begin
               pre_n       = 2'd2;
               pre0.kind   = KIND_NUMBER;
               pre0.length = len_dot;
            end
            default: begin
               pre_n = 2'd0;
            end
         endcase
         tail       = make_token(KIND_EOF, pos, '0, state.line, STATUS_OK);
         tail_valid = 1'b1;
         state_next = STATE_RESET;
      end else begin
         unique case (state.mode)
            MODE_OPER: begin
               state_next.mode = MODE_IDLE;
               pre_n           = 2'd1;
               if (source_char == CHAR_EQUAL) begin
                  op_code     = {state.op, 1'b1};
                  pre0.kind   = KIND_BANG + KIND_WIDTH'(op_code);
                  pre0.length = len_nxt;
               end else begin
                  do_fresh = 1'b1;
               end
            end
            MODE_SLASH: begin
               if (source_char == CHAR_SLASH) begin
                  state_next.mode = MODE_COMMENT;
               end else begin
                  pre_n     = 2'd1;
                  pre0.kind = KIND_SLASH;
                  do_fresh  = 1'b1;
               end
            end
            MODE_COMMENT: begin
               do_fresh = (source_char == CHAR_NEWLINE);
            end
            MODE_STRING: begin
               if (source_char == CHAR_NEWLINE) begin
                  line_bump = 1'b1;
               end else if (source_char == CHAR_QUOTE) begin
                  pre_n           = 2'd1;
                  pre0.kind       = KIND_STRING;
                  pre0.length     = len_nxt;
                  state_next.mode = MODE_IDLE;
               end
            end
            MODE_INT: begin
               if (source_char == CHAR_DOT) begin
                  state_next.mode = MODE_DOT;
               end else if (!is_digit) begin
                  pre_n     = 2'd1;
                  pre0.kind = KIND_NUMBER;
                  do_fresh  = 1'b1;
               end
            end
            MODE_DOT: begin
               if (is_digit) begin
                  state_next.mode = MODE_FRAC;
               end else begin
                  pre_n       = 2'd2;
                  pre0.kind   = KIND_NUMBER;
                  pre0.length = len_dot;
                  do_fresh    = 1'b1;
               end
            end
            MODE_FRAC: begin
               if (!is_digit) begin
                  pre_n     = 2'd1;
                  pre0.kind = KIND_NUMBER;
                  do_fresh  = 1'b1;
               end
            end
            default: begin
               do_fresh = 1'b1;
            end
         endcase

         // rescan the character with the scanner idle
         if (do_fresh) begin
            state_next.mode      = fresh_mode;
            state_next.op        = fresh_op;
            state_next.start_off = pos;
            tail_valid           = fresh_tok_valid;
            line_bump            = fresh_newline;
         end
         state_next.line = line_bump ? line_inc : state.line;
      end
   end

   // pack the tokens in emission order and mark the last one
   always_comb begin
      push.count   = RESULT_CNT_WIDTH'(pre_n) + RESULT_CNT_WIDTH'(tail_valid);
      push.slot[0] = (pre_n != 2'd0) ? pre0 : tail;
      push.slot[1] = (pre_n == 2'd2) ? pre1 : tail;
      push.slot[2] = tail;
      if (push.count != '0) begin
         push.slot[push.count - RESULT_CNT_WIDTH'(1)].last = 1'b1;
      end
   end

endmodule

@@ rtl/slx_queue.sv @@
// ----------------------------------------------------------------------------
// slx_queue: result queue
// Takes up to three token words in one cycle and hands them out one per
// cycle on the result channel while head_stall is low. Signals full while
// fewer than three entries are free.
// ----------------------------------------------------------------------------
module slx_queue
   import slx_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push_valid,
   input  push_type  push,
   output logic      full,
   output logic      head_valid,
   output token_type head,
   input  logic      head_stall
);

   token_type                  entry_ff [QUEUE_DEPTH];
   logic [QUEUE_IDX_WIDTH-1:0] wr_ptr_ff;
   logic [QUEUE_IDX_WIDTH-1:0] wr_ptr_in;
   logic [QUEUE_IDX_WIDTH-1:0] rd_ptr_ff;
   logic [QUEUE_IDX_WIDTH-1:0] rd_ptr_in;
   logic [QUEUE_CNT_WIDTH-1:0] count_ff;
   logic [QUEUE_CNT_WIDTH-1:0] count_in;
   logic [QUEUE_CNT_WIDTH-1:0] push_n;
   logic                       pop;

   assign head_valid = (count_ff != '0);
   assign head       = entry_ff[rd_ptr_ff];
   assign pop        = head_valid && !head_stall;
   assign full       = count_ff > QUEUE_CNT_WIDTH'(QUEUE_DEPTH - RESULT_MAX);
   assign push_n     = push_valid ? QUEUE_CNT_WIDTH'(push.count) : '0;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff + push_n[QUEUE_IDX_WIDTH-1:0];
      rd_ptr_in = pop ? rd_ptr_ff + QUEUE_IDX_WIDTH'(1) : rd_ptr_ff;
      count_in  = count_ff + push_n - QUEUE_CNT_WIDTH'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // token words written at consecutive entries
   always_ff @(posedge clock) begin
      for (int i = 0; i < RESULT_MAX; i++) begin
         if (push_valid && (RESULT_CNT_WIDTH'(i) < push.count)) begin
            entry_ff[wr_ptr_ff + QUEUE_IDX_WIDTH'(i)] <= push.slot[i];
         end
      end
   end

endmodule

@@ rtl/source_lexer_step.sv @@
// ----------------------------------------------------------------------------
// source_lexer_step: streaming scanner, one source byte per word
// Scanner state register, step logic and result queue.
// ----------------------------------------------------------------------------
// The block takes one source byte per cycle while req_stall is low and
// scans it in a single pass between the state register and a four-entry
// result queue. The tokens that a byte completes go into the queue and
// come out one per cycle on the rsp_ channel while rsp_stall is low. A
// byte that completes two or three tokens (an operator, slash or number
// closed by a one-byte token or a bad byte, a number ending in a dot, or
// the end mark behind an open token) stalls the req_ channel until the
// queue has three free entries again, so the input rate is bounded by the
// one-word-per-cycle drain of that queue. After the end mark the scanner
// is back in its reset state and the next byte starts a new source.
module source_lexer_step
   import slx_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [7:0]              req_source_char,
   input  logic                    req_end_of_source,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [KIND_WIDTH-1:0]   rsp_token_kind,
   output logic [OFFSET_WIDTH-1:0] rsp_token_start,
   output logic [OFFSET_WIDTH-1:0] rsp_token_length,
   output logic [LINE_WIDTH-1:0]   rsp_token_line,
   output logic [STATUS_WIDTH-1:0] rsp_status,
   output logic                    rsp_last_of_run
);

   state_type state_ff;
   state_type state_in;
   state_type step_next;
   push_type  push;
   token_type head;
   logic      accept;
   logic      queue_full;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;

   // scan step
   slx_step u_slx_step (
      .state         (state_ff),
      .source_char   (req_source_char),
      .end_of_source (req_end_of_source),
      .state_next    (step_next),
      .push          (push)
   );

   // scanner state register
   assign state_in = accept ? step_next : state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_RESET;
      end else begin
         state_ff <= state_in;
      end
   end

   // token words out
   slx_queue u_slx_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (accept),
      .push       (push),
      .full       (queue_full),
      .head_valid (rsp_valid),
      .head       (head),
      .head_stall (rsp_stall)
   );

   assign rsp_token_kind   = head.kind;
   assign rsp_token_start  = head.start;
   assign rsp_token_length = head.length;
   assign rsp_token_line   = head.line;
   assign rsp_status       = head.status;
   assign rsp_last_of_run  = head.last;

endmodule

@@ rtl/slx_checker.sv @@
// ----------------------------------------------------------------------------
// slx_checker: port checks of the source lexer
// Watches the result channel for words that the scanner cannot produce.
// ----------------------------------------------------------------------------
module slx_checker
   import slx_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    rsp_valid,
   input logic                    rsp_stall,
   input logic [KIND_WIDTH-1:0]   rsp_token_kind,
   input logic [OFFSET_WIDTH-1:0] rsp_token_start,
   input logic [OFFSET_WIDTH-1:0] rsp_token_length,
   input logic [LINE_WIDTH-1:0]   rsp_token_line,
   input logic [STATUS_WIDTH-1:0] rsp_status,
   input logic                    rsp_last_of_run
);

   // a stalled word keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_token_kind)
         && $stable(rsp_token_start) && $stable(rsp_token_length)
         && $stable(rsp_token_line) && $stable(rsp_status) && $stable(rsp_last_of_run))
      else $error("result word changed while stalled");

   // eof always closes the run of its end mark and is empty
   a_eof_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_token_kind == KIND_EOF)
         |-> rsp_last_of_run && (rsp_token_length == '0) && (rsp_status == STATUS_OK))
      else $error("eof word not last or not empty");

   // an unexpected character is a one byte word
   a_unexpected: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_UNEXPECTED)
         |-> (rsp_token_kind == KIND_LPAREN) && (rsp_token_length == OFFSET_WIDTH'(1)))
      else $error("unexpected character word malformed");

   // only a string can be unterminated, and eof follows it
   a_unterminated: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_UNTERMINATED)
         |-> (rsp_token_kind == KIND_STRING) && !rsp_last_of_run)
      else $error("unterminated status on a word other than a string");

   // the line number never drops to zero
   a_line_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_token_line != '0))
      else $error("token line is zero");

endmodule

bind source_lexer_step slx_checker u_slx_checker (.*);
